// ----- rtl/core/flpc_pkg.sv -----
package flpc_pkg;

  localparam int WEIGHT_REGS      = 8;
  localparam int WEIGHT_W         = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int FRAC_SHIFT       = 14;
  localparam int CENTER_TAP       = 3;
  localparam logic signed [WEIGHT_W-1:0] CENTER_RESET = 16'sd16384;

  // step queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic emit;   // step produces a result
    logic last;   // final step of the sequence: result is last, then clear line
  } flpc_flags_t;

  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] level;
  } flpc_qstat_t;

  typedef struct packed {
    logic flushing;
  } flpc_fstat_t;

endpackage

// ----- rtl/core/flpc_front.sv -----
module flpc_front import flpc_pkg::*; #(
  parameter int TAPS         = 8,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_last,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    in_ready,
  input  flpc_qstat_t             q_stat,
  output logic                    push,
  output flpc_flags_t             push_flags,
  output logic [SAMPLE_WIDTH-1:0] push_sample,
  output flpc_fstat_t             fstat
);

  localparam int OFFSET = (TAPS - 1) / 2;
  localparam int CNT_W  = (OFFSET > 0) ? $clog2(OFFSET + 1) : 1;
  localparam logic [CNT_W-1:0] OFF_C = CNT_W'(OFFSET);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic             flush_r, flush_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] seen_inc;
  logic             accept;

  assign in_ready       = !flush_r && !q_stat.full;
  assign accept         = in_valid && in_ready;
  assign seen_inc       = (seen_r == OFF_C) ? seen_r : seen_r + ONE_C;
  assign fstat.flushing = flush_r;

  always_comb begin
    flush_nxt       = flush_r;
    seen_nxt        = seen_r;
    left_nxt        = left_r;
    push            = 1'b0;
    push_flags.emit = (seen_r >= OFF_C);
    push_flags.last = 1'b0;
    push_sample     = in_sample;
    if (accept) begin
      push     = 1'b1;
      seen_nxt = seen_inc;
      if (in_last) begin
        if (OFFSET == 0) begin
          push_flags.last = 1'b1;
          seen_nxt        = '0;
        end else begin
          flush_nxt = 1'b1;
          left_nxt  = OFF_C;
        end
      end
    end else if (flush_r && !q_stat.full) begin
      // feed a zero sample for each remaining aligned result
      push            = 1'b1;
      push_sample     = '0;
      push_flags.last = (left_r == ONE_C);
      left_nxt        = left_r - ONE_C;
      if (left_r == ONE_C) begin
        flush_nxt = 1'b0;
        seen_nxt  = '0;
      end else begin
        seen_nxt = seen_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r <= 1'b0;
      seen_r  <= '0;
      left_r  <= '0;
    end else begin
      flush_r <= flush_nxt;
      seen_r  <= seen_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- rtl/core/flpc_queue.sv -----
module flpc_queue import flpc_pkg::*; #(
  parameter int WIDTH = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output flpc_qstat_t      stat
);

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] level_r, level_nxt;

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.valid = (level_r != '0);
  assign stat.full  = (level_r == QCNT_W'(QDEPTH));

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QCNT_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

endmodule

// ----- rtl/core/flpc_back.sv -----
module flpc_back import flpc_pkg::*; #(
  parameter int TAPS         = 8,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [WEIGHT_W-1:0]     cfg_wdata,
  input  logic                    q_valid,
  input  flpc_flags_t             q_flags,
  input  logic [SAMPLE_WIDTH-1:0] q_sample,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_data,
  output logic                    out_last
);

  localparam int PROD_W = SAMPLE_WIDTH + WEIGHT_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] MAX_V   =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN_V   = ~MAX_V;

  logic signed [WEIGHT_W-1:0]     w_r    [WEIGHT_REGS];
  logic signed [SAMPLE_WIDTH-1:0] dl_r   [TAPS-1];
  logic signed [SAMPLE_WIDTH-1:0] taps   [TAPS];
  logic signed [PROD_W-1:0]       prod_r [TAPS];
  logic                           p_valid_r, p_last_r;
  logic signed [ACC_W-1:0]        acc, acc_r;
  logic                           s_valid_r, s_last_r;
  logic signed [ACC_W-1:0]        rnd, shifted;
  logic [SAMPLE_WIDTH-1:0]        sat;
  logic                           out_valid_r, out_last_r;
  logic [SAMPLE_WIDTH-1:0]        out_data_r;
  logic                           en;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_comb begin
    taps[0] = q_sample;
    for (int j = 1; j < TAPS; j++) begin
      taps[j] = dl_r[j-1];
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      acc = acc + ACC_W'(prod_r[j]);
    end
  end

  // round half up, then clamp to the sample range
  always_comb begin
    rnd     = acc_r + ROUND_C;
    shifted = rnd >>> FRAC_SHIFT;
    if (shifted > MAX_V) begin
      sat = MAX_V[SAMPLE_WIDTH-1:0];
    end else if (shifted < MIN_V) begin
      sat = MIN_V[SAMPLE_WIDTH-1:0];
    end else begin
      sat = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < TAPS; j++) begin
        prod_r[j] <= taps[j] * w_r[j];
      end
      p_last_r   <= q_flags.last;
      acc_r      <= acc;
      s_last_r   <= p_last_r;
      out_data_r <= sat;
      out_last_r <= s_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WEIGHT_REGS; k++) begin
        w_r[k] <= (k == CENTER_TAP) ? CENTER_RESET : '0;
      end
      for (int j = 0; j < TAPS - 1; j++) begin
        dl_r[j] <= '0;
      end
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        w_r[cfg_index] <= cfg_wdata;
      end
      if (q_pop) begin
        if (q_flags.last) begin
          for (int j = 0; j < TAPS - 1; j++) begin
            dl_r[j] <= '0;
          end
        end else begin
          dl_r[0] <= q_sample;
          for (int j = 1; j < TAPS - 1; j++) begin
            dl_r[j] <= dl_r[j-1];
          end
        end
      end
      if (en) begin
        p_valid_r   <= q_pop && q_flags.emit;
        s_valid_r   <= p_valid_r;
        out_valid_r <= s_valid_r;
      end
    end
  end

endmodule

// ----- rtl/core/fir_lowpass_centered_unit.sv -----
// Centered FIR over finite sample sequences: each sequence of N samples (the
// last one flagged by in_tlast) yields exactly N filtered samples, the final
// one flagged by out_tlast. Samples outside the sequence count as zero, so the
// first (TAPS-1)/2 samples of a sequence produce no result and the flagged
// sample is followed by (TAPS-1)/2 internal zero steps that produce the tail.
// Rate: one sample per clock while the step queue has room; a sample flagged
// last holds in_tready low while the front issues the zero steps (longer
// while the step queue is full). A request passes through the step queue
// write, the product stage, the sum stage and then the output register
// before out_tvalid rises. Weights are Q1.14, written through cfg_*; the
// user must write them only while the block is idle, as the block itself
// does not enforce this; the sum is rounded half up and saturated.
module fir_lowpass_centered_unit import flpc_pkg::*; #(
  parameter int TAPS         = 8,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // cfg: write tap weight cfg_index
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_wdata,
  // in_tdata: sample_in [SAMPLE_WIDTH-1:0], zero padded; in_tlast: end_of_sequence
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] in_tdata,
  input  logic                                  in_tlast,
  // out_tdata: filtered_out [SAMPLE_WIDTH-1:0], zero padded; out_tlast: last_result
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8)*8-1:0] out_tdata,
  output logic                                  out_tlast
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OFFSET  = (TAPS - 1) / 2;
  localparam int QW      = SAMPLE_WIDTH + $bits(flpc_flags_t);

  flpc_qstat_t             q_stat;
  flpc_fstat_t             fstat;
  logic                    push, pop;
  flpc_flags_t             push_flags, head_flags;
  logic [SAMPLE_WIDTH-1:0] push_sample, head_sample;
  logic [SAMPLE_WIDTH-1:0] out_data;

  // front: accept requests, track position in the sequence, issue zero steps
  flpc_front #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_last     (in_tlast),
    .in_sample   (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_ready    (in_tready),
    .q_stat      (q_stat),
    .push        (push),
    .push_flags  (push_flags),
    .push_sample (push_sample),
    .fstat       (fstat)
  );

  // queue: decouple step issue from the filter pipeline stall
  flpc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_flags, push_sample}),
    .pop       (pop),
    .head_data ({head_flags, head_sample}),
    .stat      (q_stat)
  );

  // back: delay line, multiply, sum, round and saturate
  flpc_back #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_stat.valid),
    .q_flags   (head_flags),
    .q_sample  (head_sample),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(out_data);

  // a sample flagged last must block input while the tail is issued
  assert property (@(posedge clk) disable iff (!rst_n)
    (OFFSET > 0) && in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input not held during tail flush");

  // input back-pressure comes only from a full queue or a flush in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_stat.full || fstat.flushing))
    else $error("input stalled without cause");

  // queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= QCNT_W'(QDEPTH))
    else $error("step queue overflow");

  // a pop only ever takes a stored step
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_stat.level != '0))
    else $error("step queue underflow");

endmodule
